>>> sv/gabm_pkg.sv
// gabm_pkg: shared types and constants for the glyph atlas binarize/measure block.
// No dependencies; used by glyph_atlas_binarize_measure_top.

package gabm_pkg;

  // Item kind carried on in_tuser
  typedef enum logic {
    FUNC_PIXEL = 1'b0,
    FUNC_QUERY = 1'b1
  } func_t;

  // Register word index (paddr[2])
  typedef enum logic {
    REG_GLYPH_WIDTH  = 1'b0,
    REG_GLYPH_HEIGHT = 1'b1
  } reg_idx_t;

  localparam int unsigned DIM_W            = 7;   // glyph_width / glyph_height register width
  localparam int unsigned ROW_W            = 6;   // row counter width
  localparam int unsigned ADV_W            = 7;   // advance field width
  localparam int unsigned CODE_W           = 8;   // glyph_code field width
  localparam int unsigned PIX_W            = 32;  // RGBA word
  localparam int unsigned CFG_ADDR_W       = 3;
  localparam int unsigned CFG_DATA_W       = 32;
  localparam int unsigned IN_DATA_W        = 40;  // pixel + glyph_code
  localparam int unsigned OUT_DATA_W       = 8;   // mask_bit + advance
  localparam logic [DIM_W-1:0]  DIM_RESET        = 7'd8;
  localparam logic [DIM_W-1:0]  MAX_GLYPH_HEIGHT = 7'd64;
  localparam logic [CODE_W-1:0] SPACE_GLYPH      = 8'd32;

  // Per-item control carried from the input stage to the result stage
  typedef struct packed {
    func_t func;
    logic  set;       // pixel had a nonzero byte
    logic  first_px;  // row 0, column 0 of the glyph: entry restarts
    logic  space;     // pixel belongs to the space glyph
    logic  done;      // last pixel of the atlas
    logic  oor;       // query code beyond the table
  } s1_ctrl_t;

endpackage

>>> sv/gabm_ram.sv
// gabm_ram: generic single-write, single-read RAM with registered read data.
// No dependencies; holds the glyph width table.

module gabm_ram #(
  parameter int unsigned WIDTH = 6,
  parameter int unsigned DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  // Write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Registered read; holds when not enabled
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

>>> sv/glyph_atlas_binarize_measure_top.sv
// glyph_atlas_binarize_measure_top: binarizes atlas pixels, keeps per-glyph widths and answers width queries.
// Depends on gabm_pkg and gabm_ram.
//
//  channel | direction | tdata / tuser                          | tlast
//  --------+-----------+----------------------------------------+-----------
//  in_     | in        | [31:0] pixel, [39:32] glyph_code; tuser=func | -
//  out_    | out       | [0] mask_bit, [7:1] advance            | atlas_done
//  cfg_    | in        | APB, 0x0 glyph_width, 0x4 glyph_height | -
//
// One word per cycle sustained while the output is not stalled; each word passes the stage 1
// registers, then the output register. Stage 1 issues the width table read; stage 2 does the
// read-modify-write and fills the output register. The table port (one read, one write) sets the rate.
// Synchronous active-low reset clears the counters, stage valids and table valid bits, and sets both dimensions to 8.
// A stalled output holds both stages; the input then takes a word only while stage 1 is empty.

module glyph_atlas_binarize_measure_top #(
  parameter int unsigned GLYPH_COUNT     = 256,
  parameter int unsigned MAX_GLYPH_WIDTH = 64
) (
  input  logic                                clk,
  input  logic                                rst_n,
  // input words
  input  logic                                in_tvalid,
  output logic                                in_tready,
  input  logic [gabm_pkg::IN_DATA_W-1:0]      in_tdata,   // [31:0] pixel, [39:32] glyph_code
  input  logic                                in_tuser,   // [0] func
  // result words
  output logic                                out_tvalid,
  input  logic                                out_tready,
  output logic [gabm_pkg::OUT_DATA_W-1:0]     out_tdata,  // [0] mask_bit, [7:1] advance
  output logic                                out_tlast,  // atlas_done
  // configuration
  input  logic                                cfg_psel,
  input  logic                                cfg_penable,
  input  logic                                cfg_pwrite,
  input  logic [gabm_pkg::CFG_ADDR_W-1:0]     cfg_paddr,
  input  logic [gabm_pkg::CFG_DATA_W-1:0]     cfg_pwdata,
  output logic [gabm_pkg::CFG_DATA_W-1:0]     cfg_prdata,
  output logic                                cfg_pready
);

  localparam int unsigned GI_W = (GLYPH_COUNT > 1) ? $clog2(GLYPH_COUNT) : 1;
  localparam int unsigned CW   = (MAX_GLYPH_WIDTH > 1) ? $clog2(MAX_GLYPH_WIDTH) : 1;
  localparam int unsigned GC_W = GI_W + 1;

  // ---------------- configuration ----------------
  logic [gabm_pkg::DIM_W-1:0] glyph_width_r, glyph_height_r;
  logic                       cfg_wr;
  gabm_pkg::reg_idx_t         cfg_idx;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel & cfg_penable & cfg_pwrite & cfg_pready;
  assign cfg_idx    = gabm_pkg::reg_idx_t'(cfg_paddr[2]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      glyph_width_r  <= gabm_pkg::DIM_RESET;
      glyph_height_r <= gabm_pkg::DIM_RESET;
    end else if (cfg_wr) begin
      case (cfg_idx)
        gabm_pkg::REG_GLYPH_WIDTH:  glyph_width_r  <= cfg_pwdata[gabm_pkg::DIM_W-1:0];
        gabm_pkg::REG_GLYPH_HEIGHT: glyph_height_r <= cfg_pwdata[gabm_pkg::DIM_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      gabm_pkg::REG_GLYPH_WIDTH:  cfg_prdata = gabm_pkg::CFG_DATA_W'(glyph_width_r);
      gabm_pkg::REG_GLYPH_HEIGHT: cfg_prdata = gabm_pkg::CFG_DATA_W'(glyph_height_r);
      default:                    cfg_prdata = '0;
    endcase
  end

  // Clamped cell dimensions: zero acts as one, overlarge as the maximum
  logic [gabm_pkg::DIM_W-1:0] dim_w, dim_h;

  always_comb begin
    if (glyph_width_r == '0) begin
      dim_w = gabm_pkg::DIM_W'(1);
    end else if (glyph_width_r > gabm_pkg::DIM_W'(MAX_GLYPH_WIDTH)) begin
      dim_w = gabm_pkg::DIM_W'(MAX_GLYPH_WIDTH);
    end else begin
      dim_w = glyph_width_r;
    end
    if (glyph_height_r == '0) begin
      dim_h = gabm_pkg::DIM_W'(1);
    end else if (glyph_height_r > gabm_pkg::MAX_GLYPH_HEIGHT) begin
      dim_h = gabm_pkg::MAX_GLYPH_HEIGHT;
    end else begin
      dim_h = glyph_height_r;
    end
  end

  // ---------------- handshake ----------------
  logic s1_v_r, out_v_r;
  logic out_free, s1_commit, in_acc;

  assign out_free  = !out_v_r || out_tready;
  assign s1_commit = s1_v_r && out_free;
  assign in_tready = !s1_v_r || out_free;
  assign in_acc    = in_tvalid && in_tready;

  // ---------------- input fields ----------------
  gabm_pkg::func_t                in_func;
  logic [gabm_pkg::PIX_W-1:0]     in_pixel;
  logic [gabm_pkg::CODE_W-1:0]    in_code;

  assign in_func  = gabm_pkg::func_t'(in_tuser);
  assign in_pixel = in_tdata[gabm_pkg::PIX_W-1:0];
  assign in_code  = in_tdata[gabm_pkg::PIX_W +: gabm_pkg::CODE_W];

  // ---------------- raster position ----------------
  logic [CW-1:0]              col_r, col_nxt;
  logic [GI_W-1:0]            gidx_r, gidx_nxt;
  logic [gabm_pkg::ROW_W-1:0] row_r, row_nxt;
  logic                       last_col, last_glyph, last_row;
  logic                       pix_acc;

  assign pix_acc    = in_acc && (in_func == gabm_pkg::FUNC_PIXEL);
  assign last_col   = (gabm_pkg::DIM_W'(col_r) + gabm_pkg::DIM_W'(1)) >= dim_w;
  assign last_glyph = (GC_W'(gidx_r) + GC_W'(1)) >= GC_W'(GLYPH_COUNT);
  assign last_row   = (gabm_pkg::DIM_W'(row_r) + gabm_pkg::DIM_W'(1)) >= dim_h;

  // Column, then glyph, then row; wraps to the atlas start
  always_comb begin
    col_nxt  = col_r;
    gidx_nxt = gidx_r;
    row_nxt  = row_r;
    if (pix_acc) begin
      if (!last_col) begin
        col_nxt = col_r + CW'(1);
      end else begin
        col_nxt = '0;
        if (!last_glyph) begin
          gidx_nxt = gidx_r + GI_W'(1);
        end else begin
          gidx_nxt = '0;
          row_nxt  = last_row ? '0 : row_r + gabm_pkg::ROW_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r  <= '0;
      gidx_r <= '0;
      row_r  <= '0;
    end else begin
      col_r  <= col_nxt;
      gidx_r <= gidx_nxt;
      row_r  <= row_nxt;
    end
  end

  // ---------------- stage 1: table read issue ----------------
  gabm_pkg::s1_ctrl_t s1_ctrl_nxt, s1_ctrl_r;
  logic [GI_W-1:0]    rd_addr, s1_addr_r;
  logic [CW-1:0]      s1_col_r;
  logic               s1_byp_r;
  logic [CW-1:0]      s1_byp_data_r;
  logic               wr_en;
  logic [CW-1:0]      wr_data;
  logic [CW-1:0]      rd_data;

  assign rd_addr = (in_func == gabm_pkg::FUNC_QUERY) ? in_code[GI_W-1:0] : gidx_r;

  always_comb begin
    s1_ctrl_nxt.func     = in_func;
    s1_ctrl_nxt.set      = (in_func == gabm_pkg::FUNC_PIXEL) && (in_pixel != '0);
    s1_ctrl_nxt.first_px = (row_r == '0) && (col_r == '0);
    s1_ctrl_nxt.space    = gabm_pkg::CODE_W'(gidx_r) == gabm_pkg::SPACE_GLYPH;
    s1_ctrl_nxt.done     = (in_func == gabm_pkg::FUNC_PIXEL) &&
                           last_col && last_glyph && last_row;
    s1_ctrl_nxt.oor      = (GC_W + 1)'(in_code) >= (GC_W + 1)'(GLYPH_COUNT);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (in_tready) begin
      s1_v_r <= in_tvalid;
    end
  end

  // Payload; a write landing in the read cycle is forwarded
  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_ctrl_r     <= s1_ctrl_nxt;
      s1_addr_r     <= rd_addr;
      s1_col_r      <= col_r;
      s1_byp_r      <= wr_en && (s1_addr_r == rd_addr);
      s1_byp_data_r <= wr_data;
    end
  end

  // ---------------- width table ----------------
  logic [GLYPH_COUNT-1:0] tbl_vld_r;

  gabm_ram #(
    .WIDTH (CW),
    .DEPTH (GLYPH_COUNT)
  ) u_width_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (s1_addr_r),
    .wr_data (wr_data),
    .rd_en   (in_acc),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tbl_vld_r <= '0;
    end else if (wr_en) begin
      tbl_vld_r[s1_addr_r] <= 1'b1;
    end
  end

  // ---------------- stage 2: update and result ----------------
  logic [CW-1:0]             stored, base;
  logic [gabm_pkg::ADV_W-1:0] adv;

  always_comb begin
    if (!tbl_vld_r[s1_addr_r]) begin
      stored = '0;
    end else if (s1_byp_r) begin
      stored = s1_byp_data_r;
    end else begin
      stored = rd_data;
    end

    base = s1_ctrl_r.first_px ? '0 : stored;
    if (s1_ctrl_r.space) begin
      wr_data = CW'(dim_w >> 2);
    end else if (s1_ctrl_r.set && (s1_col_r > base)) begin
      wr_data = s1_col_r;
    end else begin
      wr_data = base;
    end

    adv = s1_ctrl_r.oor ? gabm_pkg::ADV_W'(1)
                        : gabm_pkg::ADV_W'(stored) + gabm_pkg::ADV_W'(1);
  end

  assign wr_en = s1_commit && (s1_ctrl_r.func == gabm_pkg::FUNC_PIXEL);

  // ---------------- output register ----------------
  logic                       out_mask_r, out_done_r;
  logic [gabm_pkg::ADV_W-1:0] out_adv_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (out_free) begin
      out_v_r <= s1_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_commit) begin
      out_mask_r <= s1_ctrl_r.set;
      out_done_r <= s1_ctrl_r.done;
      out_adv_r  <= (s1_ctrl_r.func == gabm_pkg::FUNC_QUERY) ? adv : '0;
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = {out_adv_r, out_mask_r};
  assign out_tlast  = out_done_r;

endmodule
